@@ rtl/qtok_pkg.sv @@
// shared types and constants of the quote-aware line tokeniser
// no dependencies; imported by qtok_step and quote_aware_line_tokenizer_core
package qtok_pkg;

	localparam int CHAR_W          = 8;
	localparam int COUNT_W         = 8;
	localparam int LEVEL_W         = 4;
	localparam int QUOTE_DEPTH_DEF = 8;
	localparam int IN_TDATA_W      = 8;
	localparam int OUT_TDATA_W     = 24;

	localparam logic [CHAR_W-1:0]  CHAR_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0]  CHAR_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0]  CHAR_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'h0d;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hff;

	// quote kind kept on the stack
	localparam logic KIND_DOUBLE = 1'b0;
	localparam logic KIND_SINGLE = 1'b1;

	// one result beat
	typedef struct packed {
		logic [CHAR_W-1:0]  out_char;
		logic               token_start;
		logic               token_end;
		logic               end_of_line;
		logic [COUNT_W-1:0] token_count;
		logic               unterminated_quote;
		logic               depth_overflow;
	} result_t;

	// result plus state update produced by the step logic
	typedef struct packed {
		result_t            res;
		logic [LEVEL_W-1:0] level_n;
		logic               inside_n;
		logic [COUNT_W-1:0] count_n;
		logic               push_en;
		logic               push_kind;
	} step_t;

endpackage

@@ rtl/qtok_step.sv @@
// per-byte tokeniser logic: classifies the byte, updates quote level and token state
// depends on qtok_pkg; purely combinational, used by quote_aware_line_tokenizer_core
module qtok_step #(
	parameter int QUOTE_DEPTH = qtok_pkg::QUOTE_DEPTH_DEF
) (
	input  logic [qtok_pkg::CHAR_W-1:0]  char_code,
	input  logic                         last,
	input  logic [qtok_pkg::LEVEL_W-1:0] level,
	input  logic                         inside_tok,
	input  logic [qtok_pkg::COUNT_W-1:0] count,
	input  logic                         top_kind,
	output qtok_pkg::step_t              step
);
	import qtok_pkg::*;

	logic               is_space;
	logic               is_quote;
	logic               kind;
	logic [LEVEL_W-1:0] lvl;
	logic               ins;
	logic [COUNT_W-1:0] cnt;

	// byte classes
	assign is_space = (char_code == CHAR_SPACE) ||
		((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
	assign is_quote = (char_code == CHAR_DQUOTE) || (char_code == CHAR_SQUOTE);
	assign kind     = (char_code == CHAR_SQUOTE) ? KIND_SINGLE : KIND_DOUBLE;

	// token and quote stack update
	always_comb begin
		step = '0;
		step.res.out_char    = char_code;
		step.res.end_of_line = last;
		step.push_kind       = kind;
		lvl = level;
		ins = inside_tok;
		cnt = count;
		if ((level == '0) && is_space) begin
			if (inside_tok) begin
				step.res.out_char  = '0;
				step.res.token_end = 1'b1;
				ins = 1'b0;
				if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
			end
		end else begin
			if (!inside_tok) begin
				ins = 1'b1;
				step.res.token_start = 1'b1;
			end
			if (is_quote) begin
				priority if ((level != '0) && (top_kind == kind)) begin
					lvl = level - 1'b1;
				end else if (level < LEVEL_W'(QUOTE_DEPTH)) begin
					lvl = level + 1'b1;
					step.push_en = 1'b1;
				end else begin
					step.res.depth_overflow = 1'b1;
				end
			end
		end
		// line end closes or drops the open token
		if (last && ins) begin
			if (lvl == '0) begin
				step.res.token_end = 1'b1;
				if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
			end else begin
				step.res.unterminated_quote = 1'b1;
			end
		end
		step.res.token_count = cnt;
		if (last) begin
			step.level_n  = '0;
			step.inside_n = 1'b0;
			step.count_n  = '0;
		end else begin
			step.level_n  = lvl;
			step.inside_n = ins;
			step.count_n  = cnt;
		end
	end

endmodule

@@ rtl/quote_aware_line_tokenizer_core.sv @@
// quote-aware line tokeniser, top level: input register, step logic, result register
// depends on qtok_pkg and qtok_step
// an accepted input beat passes the input register, then the result register, to the output
// throughput: one byte per cycle while m_tready does not stall the output; the state update for a byte is combinational
// reset: arst_n clears valid flags, quote level, token flag and token count at once;
// the quote stack itself is not reset, only levels that were pushed are ever read
module quote_aware_line_tokenizer_core #(
	parameter int QUOTE_DEPTH = qtok_pkg::QUOTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [qtok_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] char_code
	input  logic                             s_tlast,  // last
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] out_char, [8] token_start, [9] token_end, [17:10] token_count,
	// [18] unterminated_quote, [19] depth_overflow, [23:20] zero
	output logic [qtok_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast   // end_of_line
);
	import qtok_pkg::*;

	localparam int IDX_W = (QUOTE_DEPTH > 1) ? $clog2(QUOTE_DEPTH) : 1;

	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;
	logic               valid_s2;
	result_t            res_s2;
	logic [LEVEL_W-1:0] level_q;
	logic               inside_q;
	logic [COUNT_W-1:0] count_q;
	logic               stack_q [QUOTE_DEPTH];
	logic [LEVEL_W-1:0] level_dec;
	logic               top_kind;
	logic               advance;
	step_t              step;

	// stage handshake: s1 moves on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[CHAR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	// top of quote stack
	assign level_dec = level_q - 1'b1;
	assign top_kind  = (level_q != '0) ? stack_q[level_dec[IDX_W-1:0]] : KIND_DOUBLE;

	qtok_step #(
		.QUOTE_DEPTH(QUOTE_DEPTH)
	) u_step (
		.char_code (char_s1),
		.last      (last_s1),
		.level     (level_q),
		.inside_tok(inside_q),
		.count     (count_q),
		.top_kind  (top_kind),
		.step      (step)
	);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			inside_q <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			level_q  <= step.level_n;
			inside_q <= step.inside_n;
			count_q  <= step.count_n;
		end
	end

	// quote stack push
	always_ff @(posedge clk) begin
		if (advance && step.push_en) begin
			stack_q[level_q[IDX_W-1:0]] <= step.push_kind;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step.res;
		end
	end

	// output beat packing
	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.end_of_line;
	assign m_tdata  = {4'b0000, res_s2.depth_overflow, res_s2.unterminated_quote,
		res_s2.token_count, res_s2.token_end, res_s2.token_start, res_s2.out_char};

endmodule
